// ===== sv/sbc_cbr_pkg.sv =====
// Shared types and constants for the SBC frame length and bitrate calculator.
package sbc_cbr_pkg;

  localparam int FLEN_W  = 11;  // frame length in bytes, up to 1032
  localparam int KBPS_W  = 15;  // bitrate in kbps, up to 24768
  localparam int SCALE_W = 9;   // sample rate in units of 100 Hz
  localparam int RATIO_W = 4;   // bands * blocks / 16: 1, 2, 3, 4, 6 or 8
  localparam int NUM_W   = 19;  // flen * scale + 10 * ratio
  localparam int DVD_W   = 17;  // numerator after the power-of-two shift
  localparam int QUO_W   = DVD_W;
  localparam int REM_W   = 4;   // divisor is 5 or 15
  localparam int NUM_CELLS = DVD_W;

  localparam logic [15:0] RATE_16K_HZ = 16'd16000;
  localparam logic [15:0] RATE_32K_HZ = 16'd32000;
  localparam logic [15:0] RATE_44K_HZ = 16'd44100;
  localparam logic [15:0] RATE_48K_HZ = 16'd48000;

  localparam logic [SCALE_W-1:0] RATE_16K_SCALE = 9'd160;
  localparam logic [SCALE_W-1:0] RATE_32K_SCALE = 9'd320;
  localparam logic [SCALE_W-1:0] RATE_44K_SCALE = 9'd441;
  localparam logic [SCALE_W-1:0] RATE_48K_SCALE = 9'd480;

  localparam logic [1:0] ALLOC_UNKNOWN  = 2'd0;
  localparam logic [1:0] ALLOC_SNR      = 2'd1;
  localparam logic [1:0] ALLOC_LOUDNESS = 2'd2;

  localparam logic [REM_W-1:0] DIV_BY_5  = 4'd5;
  localparam logic [REM_W-1:0] DIV_BY_15 = 4'd15;

  typedef struct packed {
    logic [7:0] rate_mode_byte;
    logic [7:0] blocks_bands_byte;
    logic [7:0] pool_low;
    logic [7:0] pool_high;
  } sbc_cbr_in_t;

  typedef struct packed {
    logic [15:0]       rate_hz;
    logic [1:0]        channel_count;
    logic              joint_flag;
    logic              dual_flag;
    logic [4:0]        block_count;
    logic [3:0]        band_count;
    logic [1:0]        alloc_kind;
    logic [FLEN_W-1:0] frame_len_low;
    logic [FLEN_W-1:0] frame_len_high;
    logic [KBPS_W-1:0] kbps_low;
    logic [KBPS_W-1:0] kbps_high;
    logic              invalid;
  } sbc_cbr_out_t;

  // Decoded fields that ride along the divider chain unchanged.
  typedef struct packed {
    logic [15:0]       rate_hz;
    logic [1:0]        channel_count;
    logic              joint_flag;
    logic              dual_flag;
    logic [4:0]        block_count;
    logic [3:0]        band_count;
    logic [1:0]        alloc_kind;
    logic [FLEN_W-1:0] frame_len_low;
    logic [FLEN_W-1:0] frame_len_high;
    logic              invalid;
  } sbc_cbr_info_t;

  typedef struct packed {
    sbc_cbr_info_t      info;
    logic [SCALE_W-1:0] scale;
    logic [RATIO_W-1:0] ratio;
  } sbc_cbr_front_t;

  typedef struct packed {
    logic [DVD_W-1:0] dvd;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } sbc_cbr_lane_t;

  typedef struct packed {
    sbc_cbr_info_t    info;
    logic [REM_W-1:0] divisor;
    sbc_cbr_lane_t    lo;
    sbc_cbr_lane_t    hi;
  } sbc_cbr_cell_t;

endpackage

// ===== sv/sbc_cbr_front.sv =====
// Front end: field decode, frame lengths, then bitrate numerator and divisor.
module sbc_cbr_front import sbc_cbr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  sbc_cbr_in_t   up_data,
  output logic          valid,
  input  logic          down_ready,
  output sbc_cbr_cell_t data
);

  function automatic logic [FLEN_W-1:0] frame_len(input logic [FLEN_W-1:0] head,
                                                  input logic [5:0] mult,
                                                  input logic [13:0] extra,
                                                  input logic [7:0] pool);
    logic [13:0] bits;
    bits = 14'(mult) * 14'(pool) + extra;
    return head + FLEN_W'((bits + 14'd7) >> 3);
  endfunction

  // Stage 1: decode and frame lengths

  sbc_cbr_front_t dec;
  logic           per_chan;
  logic [5:0]     mult;
  logic [13:0]    extra;
  logic [FLEN_W-1:0] head;

  always_comb begin
    dec = '0;
    dec.info.channel_count = 2'd2;
    per_chan = 1'b0;

    priority if (up_data.rate_mode_byte[7]) begin
      dec.info.rate_hz = RATE_16K_HZ;
      dec.scale        = RATE_16K_SCALE;
    end else if (up_data.rate_mode_byte[6]) begin
      dec.info.rate_hz = RATE_32K_HZ;
      dec.scale        = RATE_32K_SCALE;
    end else if (up_data.rate_mode_byte[5]) begin
      dec.info.rate_hz = RATE_44K_HZ;
      dec.scale        = RATE_44K_SCALE;
    end else if (up_data.rate_mode_byte[4]) begin
      dec.info.rate_hz = RATE_48K_HZ;
      dec.scale        = RATE_48K_SCALE;
    end else begin
      dec.info.rate_hz = '0;
      dec.scale        = '0;
    end

    priority if (up_data.rate_mode_byte[3]) begin
      dec.info.channel_count = 2'd1;
      per_chan = 1'b1;
    end else if (up_data.rate_mode_byte[2]) begin
      dec.info.dual_flag = 1'b1;
      per_chan = 1'b1;
    end else if (up_data.rate_mode_byte[1]) begin
      per_chan = 1'b0;
    end else if (up_data.rate_mode_byte[0]) begin
      dec.info.joint_flag = 1'b1;
    end else begin
      per_chan = 1'b0;
    end

    priority if (up_data.blocks_bands_byte[7]) dec.info.block_count = 5'd4;
    else if (up_data.blocks_bands_byte[6])     dec.info.block_count = 5'd8;
    else if (up_data.blocks_bands_byte[5])     dec.info.block_count = 5'd12;
    else if (up_data.blocks_bands_byte[4])     dec.info.block_count = 5'd16;
    else                                       dec.info.block_count = 5'd0;

    priority if (up_data.blocks_bands_byte[3]) dec.info.band_count = 4'd4;
    else if (up_data.blocks_bands_byte[2])     dec.info.band_count = 4'd8;
    else                                       dec.info.band_count = 4'd0;

    priority if (up_data.blocks_bands_byte[1]) dec.info.alloc_kind = ALLOC_SNR;
    else if (up_data.blocks_bands_byte[0])     dec.info.alloc_kind = ALLOC_LOUDNESS;
    else                                       dec.info.alloc_kind = ALLOC_UNKNOWN;

    dec.info.invalid = (dec.info.band_count == 4'd0) || (dec.info.block_count == 5'd0);

    // Header: 4 bytes plus 4 bits of scale factor per band and channel.
    head = FLEN_W'(4) +
           FLEN_W'((6'(dec.info.band_count) * 6'(dec.info.channel_count)) >> 1);
    mult  = 6'(dec.info.block_count) * (per_chan ? 6'(dec.info.channel_count) : 6'd1);
    extra = dec.info.joint_flag ? 14'(dec.info.band_count) : 14'd0;

    dec.info.frame_len_low  = frame_len(head, mult, extra, up_data.pool_low);
    dec.info.frame_len_high = frame_len(head, mult, extra, up_data.pool_high);

    // bands * blocks / 16, zero when either count is missing
    dec.ratio = RATIO_W'(dec.info.band_count[3:2]) * RATIO_W'(dec.info.block_count[4:2]);
  end

  logic           s1_valid;
  sbc_cbr_front_t s1;
  logic           s1_ready;

  assign s1_ready = !valid || down_ready;
  assign up_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (up_ready) begin
      s1_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      s1 <= dec;
    end
  end

  // Stage 2: kbps = floor((flen * scale + 10 * ratio) / (20 * ratio)).
  // Split 20 * ratio into 2^shift * divisor with divisor 5 or 15.

  logic [2:0]       shift;
  logic [REM_W-1:0] divisor;
  logic [19:0]      bias;
  logic [19:0]      prod_lo, prod_hi;
  logic [NUM_W-1:0] num_lo, num_hi;
  sbc_cbr_cell_t    prep;

  always_comb begin
    unique case (s1.ratio)
      4'd1:    begin shift = 3'd2; divisor = DIV_BY_5;  end
      4'd2:    begin shift = 3'd3; divisor = DIV_BY_5;  end
      4'd3:    begin shift = 3'd2; divisor = DIV_BY_15; end
      4'd4:    begin shift = 3'd4; divisor = DIV_BY_5;  end
      4'd6:    begin shift = 3'd3; divisor = DIV_BY_15; end
      4'd8:    begin shift = 3'd5; divisor = DIV_BY_5;  end
      default: begin shift = 3'd2; divisor = DIV_BY_5;  end
    endcase

    bias    = 20'(s1.ratio) * 20'd10;
    prod_lo = 20'(s1.info.frame_len_low) * 20'(s1.scale);
    prod_hi = 20'(s1.info.frame_len_high) * 20'(s1.scale);
    num_lo  = NUM_W'(prod_lo + bias);
    num_hi  = NUM_W'(prod_hi + bias);

    prep         = '0;
    prep.info    = s1.info;
    prep.divisor = divisor;
    prep.lo.dvd  = DVD_W'(num_lo >> shift);
    prep.hi.dvd  = DVD_W'(num_hi >> shift);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s1_ready) begin
      valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      data <= prep;
    end
  end

endmodule

// ===== sv/sbc_cbr_cell.sv =====
// One restoring-division step for both bitpool lanes, with its own stage register.
module sbc_cbr_cell import sbc_cbr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  sbc_cbr_cell_t up_data,
  output logic          valid,
  input  logic          down_ready,
  output sbc_cbr_cell_t data
);

  function automatic sbc_cbr_lane_t div_step(input sbc_cbr_lane_t lane,
                                             input logic [REM_W-1:0] divisor);
    sbc_cbr_lane_t  res;
    logic [REM_W:0] trial;
    logic           fits;
    trial = {lane.rem, lane.dvd[DVD_W-1]};
    fits  = trial >= {1'b0, divisor};
    res.rem = fits ? REM_W'(trial - {1'b0, divisor}) : trial[REM_W-1:0];
    res.quo = {lane.quo[QUO_W-2:0], fits};
    res.dvd = {lane.dvd[DVD_W-2:0], 1'b0};
    return res;
  endfunction

  sbc_cbr_cell_t data_next;

  always_comb begin
    data_next    = up_data;
    data_next.lo = div_step(up_data.lo, up_data.divisor);
    data_next.hi = div_step(up_data.hi, up_data.divisor);
  end

  // Advance when this slot is empty or its content moves on.
  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

// ===== sv/sbc_config_bitrate_calc_top.sv =====
// Top level of the SBC capability decoder and frame length / bitrate calculator.
//
// Input channel (item_valid / item_ready / item): one transfer carries the four
// capability bytes and both bitpools. Output channel (result_valid /
// result_ready / result): one transfer per input item with the decoded fields,
// frame lengths for both bitpools and both bitrates in kbps, rounded half up.
//
// An item passes 19 register stages: two front stages (decode and frame
// length, then the bitrate numerator multiply) and a chain of 17 division
// cells, one quotient bit each. Throughput is one item per cycle while
// result_ready is high, set by the cell chain, which holds one item in
// every stage.
//
// Each stage moves on whenever its successor is empty or moving, so bubbles
// close up. When the receiver stalls, the last cell holds its result and
// the chain keeps taking items until every stage is full; item_ready then
// drops until result_ready returns.
//
// Reset (rst, synchronous) empties every stage; no item is in flight after it.
module sbc_config_bitrate_calc_top import sbc_cbr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  input  sbc_cbr_in_t  item,
  output logic         result_valid,
  input  logic         result_ready,
  output sbc_cbr_out_t result
);

  // Handshake and data along the chain: slot 0 is the front end's output,
  // slot NUM_CELLS is the last cell, which also serves as output register.
  logic          chain_valid [NUM_CELLS+1];
  logic          chain_ready [NUM_CELLS+1];
  sbc_cbr_cell_t chain_data  [NUM_CELLS+1];

  sbc_cbr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (item_valid),
    .up_ready   (item_ready),
    .up_data    (item),
    .valid      (chain_valid[0]),
    .down_ready (chain_ready[0]),
    .data       (chain_data[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    sbc_cbr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (chain_valid[i]),
      .up_ready   (chain_ready[i]),
      .up_data    (chain_data[i]),
      .valid      (chain_valid[i+1]),
      .down_ready (chain_ready[i+1]),
      .data       (chain_data[i+1])
    );
  end

  assign chain_ready[NUM_CELLS] = result_ready;
  assign result_valid           = chain_valid[NUM_CELLS];

  // Assemble the result; drop the bitrates when a count is missing.
  sbc_cbr_cell_t last;

  always_comb begin
    last = chain_data[NUM_CELLS];
    result.rate_hz        = last.info.rate_hz;
    result.channel_count  = last.info.channel_count;
    result.joint_flag     = last.info.joint_flag;
    result.dual_flag      = last.info.dual_flag;
    result.block_count    = last.info.block_count;
    result.band_count     = last.info.band_count;
    result.alloc_kind     = last.info.alloc_kind;
    result.frame_len_low  = last.info.frame_len_low;
    result.frame_len_high = last.info.frame_len_high;
    result.invalid        = last.info.invalid;
    result.kbps_low       = last.info.invalid ? '0 : last.lo.quo[KBPS_W-1:0];
    result.kbps_high      = last.info.invalid ? '0 : last.hi.quo[KBPS_W-1:0];
  end

endmodule
